@@ rtl/gbc_pkg.sv @@
package gbc_pkg;

	localparam int DATA_W   = 32;
	localparam int BANK_W   = 3;
	localparam int REG_W    = 4;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int LINE_W   = 6;
	localparam int PERIOD_W = 8;

	typedef logic [DATA_W-1:0]   word_t;
	typedef logic [BANK_W-1:0]   bank_t;
	typedef logic [REG_W-1:0]    reg_sel_t;
	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [LINE_W-1:0]   lines_t;
	typedef logic [PERIOD_W-1:0] period_t;

	// operations
	localparam op_t OP_READ  = 2'd0;
	localparam op_t OP_WRITE = 2'd1;
	localparam op_t OP_TICK  = 2'd2;

	// register map
	localparam reg_sel_t REG_DATAIN   = 4'd0;
	localparam reg_sel_t REG_DATAOUT  = 4'd1;
	localparam reg_sel_t REG_SETOUT   = 4'd2;
	localparam reg_sel_t REG_CLROUT   = 4'd3;
	localparam reg_sel_t REG_OE       = 4'd4;
	localparam reg_sel_t REG_IRQSTAT  = 4'd5;
	localparam reg_sel_t REG_IRQEN    = 4'd6;
	localparam reg_sel_t REG_SETIRQEN = 4'd7;
	localparam reg_sel_t REG_CLRIRQEN = 4'd8;
	localparam reg_sel_t REG_LVL0     = 4'd9;
	localparam reg_sel_t REG_LVL1     = 4'd10;
	localparam reg_sel_t REG_RISE     = 4'd11;
	localparam reg_sel_t REG_FALL     = 4'd12;
	localparam reg_sel_t REG_DBEN     = 4'd13;
	localparam reg_sel_t REG_DBTIME   = 4'd14;
	localparam reg_sel_t REG_LAST     = REG_DBTIME;

	// result status
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_BAD_BANK = 2'd1;
	localparam status_t ST_BAD_REG  = 2'd2;

	typedef struct packed {
		logic     bank_ok;
		logic     rd_en;
		logic     wr_en;
		logic     tick_en;
		reg_sel_t reg_sel;
		bank_t    bank;
		status_t  status;
	} gbc_ctrl_t;

endpackage

@@ rtl/gbc_decode.sv @@
module gbc_decode
	import gbc_pkg::*;
#(
	parameter int BANK_COUNT = 6
) (
	input  op_t       op,
	input  bank_t     bank,
	input  reg_sel_t  reg_index,
	output gbc_ctrl_t ctrl
);

	logic bank_ok;
	logic reg_ok;

	assign bank_ok = {1'b0, bank} < (BANK_W+1)'(BANK_COUNT);
	assign reg_ok  = reg_index <= REG_LAST;

	always_comb begin
		ctrl         = '0;
		ctrl.bank_ok = bank_ok;
		ctrl.reg_sel = reg_index;
		ctrl.bank    = bank;
		if (!bank_ok) begin
			ctrl.status = ST_BAD_BANK;
		end else begin
			case (op)
				OP_READ: begin
					ctrl.rd_en  = reg_ok;
					ctrl.status = reg_ok ? ST_OK : ST_BAD_REG;
				end
				OP_WRITE: begin
					// data-in is read-only
					ctrl.wr_en  = reg_ok && (reg_index != REG_DATAIN);
					ctrl.status = ctrl.wr_en ? ST_OK : ST_BAD_REG;
				end
				OP_TICK: begin
					ctrl.tick_en = 1'b1;
					ctrl.status  = ST_OK;
				end
				default: begin
					ctrl.status = ST_BAD_REG;
				end
			endcase
		end
	end

endmodule

@@ rtl/gbc_bank_file.sv @@
module gbc_bank_file
	import gbc_pkg::*;
#(
	parameter int BANK_COUNT = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      update,
	input  gbc_ctrl_t ctrl,
	input  word_t     write_data,
	input  word_t     pad_levels,
	output word_t     read_data,
	output lines_t    irq_lines,
	output word_t     drive_level,
	output word_t     drive_enable
);

	localparam int IDX_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

	word_t   pin_input_q  [BANK_COUNT];
	word_t   pin_output_q [BANK_COUNT];
	word_t   input_mode_q [BANK_COUNT];
	word_t   irq_flags_q  [BANK_COUNT];
	word_t   irq_mask_q   [BANK_COUNT];
	word_t   lvl0_q       [BANK_COUNT];
	word_t   lvl1_q       [BANK_COUNT];
	word_t   rise_q       [BANK_COUNT];
	word_t   fall_q       [BANK_COUNT];
	word_t   dben_q       [BANK_COUNT];
	period_t dbtime_q     [BANK_COUNT];

	word_t   pin_input_d  [BANK_COUNT];
	word_t   pin_output_d [BANK_COUNT];
	word_t   input_mode_d [BANK_COUNT];
	word_t   irq_flags_d  [BANK_COUNT];
	word_t   irq_mask_d   [BANK_COUNT];
	word_t   lvl0_d       [BANK_COUNT];
	word_t   lvl1_d       [BANK_COUNT];
	word_t   rise_d       [BANK_COUNT];
	word_t   fall_d       [BANK_COUNT];
	word_t   dben_d       [BANK_COUNT];
	period_t dbtime_d     [BANK_COUNT];

	logic [IDX_W-1:0] idx;

	assign idx = ctrl.bank[IDX_W-1:0];

	// next state of every bank
	always_comb begin
		word_t prev;
		word_t now;
		word_t wd;
		prev = pin_input_q[idx];
		now  = pad_levels;
		wd   = write_data;
		for (int b = 0; b < BANK_COUNT; b++) begin
			pin_input_d[b]  = pin_input_q[b];
			pin_output_d[b] = pin_output_q[b];
			input_mode_d[b] = input_mode_q[b];
			irq_flags_d[b]  = irq_flags_q[b];
			irq_mask_d[b]   = irq_mask_q[b];
			lvl0_d[b]       = lvl0_q[b];
			lvl1_d[b]       = lvl1_q[b];
			rise_d[b]       = rise_q[b];
			fall_d[b]       = fall_q[b];
			dben_d[b]       = dben_q[b];
			dbtime_d[b]     = dbtime_q[b];
		end
		if (ctrl.tick_en) begin
			irq_flags_d[idx] = irq_flags_q[idx]
				| (~now & lvl0_q[idx])
				| (now & lvl1_q[idx])
				| (~prev & now & rise_q[idx])
				| (prev & ~now & fall_q[idx]);
			pin_input_d[idx] = now;
		end
		if (ctrl.wr_en) begin
			case (ctrl.reg_sel)
				REG_DATAOUT:  pin_output_d[idx] = wd;
				REG_SETOUT:   pin_output_d[idx] = pin_output_q[idx] | wd;
				REG_CLROUT:   pin_output_d[idx] = pin_output_q[idx] & ~wd;
				REG_OE:       input_mode_d[idx] = wd;
				REG_IRQSTAT:  irq_flags_d[idx]  = irq_flags_q[idx] & ~wd;
				REG_IRQEN:    irq_mask_d[idx]   = wd;
				REG_SETIRQEN: irq_mask_d[idx]   = irq_mask_q[idx] | wd;
				REG_CLRIRQEN: irq_mask_d[idx]   = irq_mask_q[idx] & ~wd;
				REG_LVL0:     lvl0_d[idx]       = wd;
				REG_LVL1:     lvl1_d[idx]       = wd;
				REG_RISE:     rise_d[idx]       = wd;
				REG_FALL:     fall_d[idx]       = wd;
				REG_DBEN:     dben_d[idx]       = wd;
				REG_DBTIME:   dbtime_d[idx]     = wd[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BANK_COUNT; b++) begin
				pin_input_q[b]  <= '0;
				pin_output_q[b] <= '0;
				input_mode_q[b] <= '1;
				irq_flags_q[b]  <= '0;
				irq_mask_q[b]   <= '0;
				lvl0_q[b]       <= '0;
				lvl1_q[b]       <= '0;
				rise_q[b]       <= '0;
				fall_q[b]       <= '0;
				dben_q[b]       <= '0;
				dbtime_q[b]     <= '0;
			end
		end else if (update) begin
			pin_input_q  <= pin_input_d;
			pin_output_q <= pin_output_d;
			input_mode_q <= input_mode_d;
			irq_flags_q  <= irq_flags_d;
			irq_mask_q   <= irq_mask_d;
			lvl0_q       <= lvl0_d;
			lvl1_q       <= lvl1_d;
			rise_q       <= rise_d;
			fall_q       <= fall_d;
			dben_q       <= dben_d;
			dbtime_q     <= dbtime_d;
		end
	end

	// register read, from state before the request
	always_comb begin
		read_data = '0;
		if (ctrl.rd_en) begin
			case (ctrl.reg_sel)
				REG_DATAIN:                            read_data = pin_input_q[idx];
				REG_DATAOUT, REG_SETOUT, REG_CLROUT:   read_data = pin_output_q[idx];
				REG_OE:                                read_data = input_mode_q[idx];
				REG_IRQSTAT:                           read_data = irq_flags_q[idx];
				REG_IRQEN, REG_SETIRQEN, REG_CLRIRQEN: read_data = irq_mask_q[idx];
				REG_LVL0:                              read_data = lvl0_q[idx];
				REG_LVL1:                              read_data = lvl1_q[idx];
				REG_RISE:                              read_data = rise_q[idx];
				REG_FALL:                              read_data = fall_q[idx];
				REG_DBEN:                              read_data = dben_q[idx];
				REG_DBTIME:  read_data = {{(DATA_W-PERIOD_W){1'b0}}, dbtime_q[idx]};
				default:                               read_data = '0;
			endcase
		end
	end

	assign drive_level  = ctrl.bank_ok ? pin_output_d[idx] : '0;
	assign drive_enable = ctrl.bank_ok ? ~input_mode_d[idx] : '0;

	// interrupt lines after the update
	for (genvar g = 0; g < LINE_W; g++) begin : g_line
		if (g < BANK_COUNT) begin : g_bank
			assign irq_lines[g] = |(irq_flags_d[g] & irq_mask_d[g]);
		end else begin : g_none
			assign irq_lines[g] = 1'b0;
		end
	end

endmodule

@@ rtl/gpio_bank_controller_top.sv @@
// GPIO controller for BANK_COUNT banks of 32 pins. Each request is a register read, a register
// write or a pad sample tick for one bank, and gives exactly one result with read data, the
// interrupt line of every bank (after the update), the drive values of the addressed bank and a
// status code. A request is taken into an input register and its result is then registered in an output
// register when that register is free, so one request is accepted every cycle while the output is not
// stalled; the bank register update is a single pass of bitwise logic on one bank. The input side
// keeps accepting while a result waits as long as the output register is freed in the same cycle.
module gpio_bank_controller_top
	import gbc_pkg::*;
#(
	parameter int BANK_COUNT = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// bank, reg_index, write_data, pad_levels, zero pad
	input  logic [71:0]  s_axis_tdata,
	// op
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// read_data, irq_lines, drive_level, drive_enable, zero pad
	output logic [103:0] m_axis_tdata,
	// status
	output logic [1:0]   m_axis_tuser
);

	logic      valid_s1;
	op_t       op_s1;
	bank_t     bank_s1;
	reg_sel_t  reg_s1;
	word_t     wdata_s1;
	word_t     pads_s1;

	logic      out_valid_q;
	word_t     read_data_q;
	lines_t    irq_lines_q;
	word_t     drive_level_q;
	word_t     drive_enable_q;
	status_t   status_q;

	logic      advance;
	logic      update;
	gbc_ctrl_t ctrl;
	word_t     read_data;
	lines_t    irq_lines;
	word_t     drive_level;
	word_t     drive_enable;

	assign advance       = !out_valid_q || m_axis_tready;
	assign update        = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1    <= s_axis_tuser;
			bank_s1  <= s_axis_tdata[2:0];
			reg_s1   <= s_axis_tdata[6:3];
			wdata_s1 <= s_axis_tdata[38:7];
			pads_s1  <= s_axis_tdata[70:39];
		end
	end

	gbc_decode #(
		.BANK_COUNT(BANK_COUNT)
	) u_decode (
		.op        (op_s1),
		.bank      (bank_s1),
		.reg_index (reg_s1),
		.ctrl      (ctrl)
	);

	gbc_bank_file #(
		.BANK_COUNT(BANK_COUNT)
	) u_bank_file (
		.clk          (clk),
		.arst_n       (arst_n),
		.update       (update),
		.ctrl         (ctrl),
		.write_data   (wdata_s1),
		.pad_levels   (pads_s1),
		.read_data    (read_data),
		.irq_lines    (irq_lines),
		.drive_level  (drive_level),
		.drive_enable (drive_enable)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			read_data_q    <= read_data;
			irq_lines_q    <= irq_lines;
			drive_level_q  <= drive_level;
			drive_enable_q <= drive_enable;
			status_q       <= ctrl.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, drive_enable_q, drive_level_q, irq_lines_q, read_data_q};
	assign m_axis_tuser  = status_q;

endmodule
